### hw/rtl/pffl_pkg.sv
package pffl_pkg;

    localparam int PAGES      = 128;
    localparam int PAGE_BYTES = 2097152;

    localparam int IDX_W      = $clog2(PAGES);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int OP_W       = 2;
    localparam int COUNT_W    = 8;
    localparam int LINK_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int ADDR_W     = 28;

    localparam logic [LINK_W-1:0]  NONE_LINK = LINK_W'(PAGES);
    localparam logic [COUNT_W-1:0] ALL_PAGES = COUNT_W'(PAGES);

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_LINK  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SHORT   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COUNT_W-1:0] count;
        logic [LINK_W-1:0]  page;
    } pffl_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LINK_W-1:0]   frame;
        logic [ADDR_W-1:0]   frame_addr;
        logic [COUNT_W-1:0]  free_pages;
    } pffl_rsp_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LINK_W-1:0]   frame;
        logic [COUNT_W-1:0]  free_pages;
    } pffl_res_t;

    typedef struct packed {
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [LINK_W-1:0] wr_data;
    } pffl_mem_req_t;

    function automatic logic [LINK_W-1:0] link_reset(input logic [IDX_W-1:0] idx);
        logic [LINK_W-1:0] v;
        if (idx == '0)
            v = NONE_LINK;
        else
            v = LINK_W'(idx) - LINK_W'(1);
        return v;
    endfunction

    function automatic logic [ADDR_W-1:0] frame_address(input logic [LINK_W-1:0] frame);
        logic [ADDR_W-1:0] a;
        if (frame < NONE_LINK)
            a = ADDR_W'(frame[IDX_W-1:0]) << PAGE_SHIFT;
        else
            a = '0;
        return a;
    endfunction

endpackage

### hw/rtl/page_frame_free_list_allocator.sv
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req (op, count, page)
// result  | rsp_valid | rsp_stall | rsp (status, frame, frame_addr, free_pages)
//
// One request at a time. Allocate unlinks count frames from the free list and
// free walks the freed list to its tail (one link-memory read per cycle);
// read link and rejected requests do not walk the list.
// Reset is immediate: per-entry valid bits stand in for the initial free chain.
// A stalled result holds in the output register; the next request is taken
// meanwhile and its result waits inside the sequencer.
module page_frame_free_list_allocator
    import pffl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  pffl_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output pffl_rsp_t rsp
);

    pffl_mem_req_t     mreq;
    logic [LINK_W-1:0] rd_data;
    logic              res_valid;
    logic              res_take;
    pffl_res_t         res;
    logic              rsp_valid_reg;
    pffl_rsp_t         rsp_reg;

    pffl_link_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .mreq    (mreq),
        .rd_data (rd_data)
    );

    pffl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .mreq      (mreq),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign res_take = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take && res_valid)
        begin
            rsp_reg.status     <= res.status;
            rsp_reg.frame      <= res.frame;
            rsp_reg.frame_addr <= frame_address(res.frame);
            rsp_reg.free_pages <= res.free_pages;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while a previous one is in progress");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.free_pages <= ALL_PAGES))
        else $error("free page count above the number of frames");

    a_fail_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != STAT_DONE)) |-> (rsp.frame == NONE_LINK))
        else $error("failed request returned a frame");

    a_none_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.frame >= NONE_LINK)) |-> (rsp.frame_addr == '0))
        else $error("address given for no frame");
`endif

endmodule

### hw/rtl/pffl_link_mem.sv
module pffl_link_mem
    import pffl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pffl_mem_req_t     mreq,
    output logic [LINK_W-1:0] rd_data
);

    logic [LINK_W-1:0] mem [PAGES];
    logic [PAGES-1:0]  valid_reg;
    logic [LINK_W-1:0] mem_q_reg;
    logic [IDX_W-1:0]  addr_q_reg;
    logic              hit_q_reg;
    logic              byp_reg;
    logic [LINK_W-1:0] byp_data_reg;

    always_ff @(posedge clk)
    begin
        if (mreq.wr_en)
        begin
            mem[mreq.wr_addr] <= mreq.wr_data;
        end
        mem_q_reg    <= mem[mreq.rd_addr];
        addr_q_reg   <= mreq.rd_addr;
        byp_data_reg <= mreq.wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_q_reg <= 1'b0;
            byp_reg   <= 1'b0;
        end
        else
        begin
            if (mreq.wr_en)
            begin
                valid_reg[mreq.wr_addr] <= 1'b1;
            end
            hit_q_reg <= valid_reg[mreq.rd_addr];
            byp_reg   <= mreq.wr_en && (mreq.wr_addr == mreq.rd_addr);
        end
    end

    // forward a write that lands on the entry being read
    always_comb
    begin
        if (byp_reg)
            rd_data = byp_data_reg;
        else if (hit_q_reg)
            rd_data = mem_q_reg;
        else
            rd_data = link_reset(addr_q_reg);
    end

endmodule

### hw/rtl/pffl_ctrl.sv
module pffl_ctrl
    import pffl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  pffl_req_t         req,
    output pffl_mem_req_t     mreq,
    input  logic [LINK_W-1:0] rd_data,
    output logic              res_valid,
    input  logic              res_take,
    output pffl_res_t         res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_FREE  = 3'd2;
    localparam logic [2:0] S_LINK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [LINK_W-1:0]   free_head_reg, free_head_next;
    logic [COUNT_W-1:0]  free_total_reg, free_total_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [LINK_W-1:0]   alloc_reg, alloc_next;
    logic [COUNT_W-1:0]  left_reg, left_next;
    logic [COUNT_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]    page_reg, page_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [LINK_W-1:0]   frame_reg, frame_next;

    logic                accept;
    logic                page_ok;
    logic                link_ok;
    logic [COUNT_W:0]    total_sum;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign page_ok   = (req.page < NONE_LINK);
    assign link_ok   = (rd_data < NONE_LINK);
    assign total_sum = {1'b0, free_total_reg} + {1'b0, len_reg};

    assign res_valid      = (state_reg == S_DONE);
    assign res.status     = status_reg;
    assign res.frame      = frame_reg;
    assign res.free_pages = free_total_reg;

    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        free_total_next = free_total_reg;
        cur_next        = cur_reg;
        alloc_next      = alloc_reg;
        left_next       = left_reg;
        len_next        = len_reg;
        page_next       = page_reg;
        status_next     = status_reg;
        frame_next      = frame_reg;
        mreq.rd_addr    = cur_reg;
        mreq.wr_en      = 1'b0;
        mreq.wr_addr    = cur_reg;
        mreq.wr_data    = alloc_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_IGNORED;
                    frame_next  = NONE_LINK;
                    state_next  = S_DONE;
                    unique case (req.op)
                        OP_ALLOC:
                        begin
                            if (req.count == '0)
                            begin
                                status_next = STAT_IGNORED;
                            end
                            else if (req.count > free_total_reg)
                            begin
                                status_next = STAT_SHORT;
                            end
                            else if (free_head_reg >= NONE_LINK)
                            begin
                                status_next = STAT_DONE;
                            end
                            else
                            begin
                                mreq.rd_addr = free_head_reg[IDX_W-1:0];
                                cur_next     = free_head_reg[IDX_W-1:0];
                                alloc_next   = NONE_LINK;
                                left_next    = req.count;
                                state_next   = S_ALLOC;
                            end
                        end
                        OP_FREE:
                        begin
                            if (page_ok)
                            begin
                                mreq.rd_addr = req.page[IDX_W-1:0];
                                cur_next     = req.page[IDX_W-1:0];
                                page_next    = req.page[IDX_W-1:0];
                                len_next     = COUNT_W'(1);
                                state_next   = S_FREE;
                            end
                        end
                        OP_LINK:
                        begin
                            if (page_ok)
                            begin
                                mreq.rd_addr = req.page[IDX_W-1:0];
                                state_next   = S_LINK;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_IGNORED;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                // unlink the current frame and push it onto the allocated list
                mreq.wr_en      = 1'b1;
                mreq.wr_addr    = cur_reg;
                mreq.wr_data    = alloc_reg;
                alloc_next      = LINK_W'(cur_reg);
                free_head_next  = rd_data;
                free_total_next = free_total_reg - COUNT_W'(1);
                left_next       = left_reg - COUNT_W'(1);
                if ((left_reg > COUNT_W'(1)) && link_ok)
                begin
                    mreq.rd_addr = rd_data[IDX_W-1:0];
                    cur_next     = rd_data[IDX_W-1:0];
                end
                else
                begin
                    status_next = STAT_DONE;
                    frame_next  = LINK_W'(cur_reg);
                    state_next  = S_DONE;
                end
            end
            S_FREE:
            begin
                if (link_ok && (len_reg < ALL_PAGES))
                begin
                    mreq.rd_addr = rd_data[IDX_W-1:0];
                    cur_next     = rd_data[IDX_W-1:0];
                    len_next     = len_reg + COUNT_W'(1);
                end
                else
                begin
                    // splice the free list behind the tail
                    mreq.wr_en     = 1'b1;
                    mreq.wr_addr   = cur_reg;
                    mreq.wr_data   = free_head_reg;
                    free_head_next = LINK_W'(page_reg);
                    if (total_sum > (COUNT_W+1)'(PAGES))
                        free_total_next = ALL_PAGES;
                    else
                        free_total_next = total_sum[COUNT_W-1:0];
                    status_next = STAT_DONE;
                    frame_next  = LINK_W'(page_reg);
                    state_next  = S_DONE;
                end
            end
            S_LINK:
            begin
                status_next = STAT_DONE;
                frame_next  = rd_data;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_head_reg  <= LINK_W'(PAGES - 1);
            free_total_reg <= ALL_PAGES;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            free_total_reg <= free_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        alloc_reg  <= alloc_next;
        left_reg   <= left_next;
        len_reg    <= len_next;
        page_reg   <= page_next;
        status_reg <= status_next;
        frame_reg  <= frame_next;
    end

endmodule

### tb/page_frame_free_list_allocator_checker.sv
module page_frame_free_list_allocator_checker
    import pffl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  pffl_req_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  pffl_rsp_t rsp,
    output int        errors,
    output int        outstanding
);

    logic [LINK_W-1:0] link_mem [PAGES];
    logic [LINK_W-1:0] head_frame;
    int unsigned       free_count;

    pffl_rsp_t expected_rsp_q[$];
    pffl_rsp_t oldest_rsp;
    pffl_rsp_t new_rsp;
    int        fail_count = 0;
    int        waiting_count = 0;

    assign errors      = fail_count;
    assign outstanding = waiting_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic predict_result(input pffl_req_t item, output pffl_rsp_t res);
        int unsigned       i;
        int unsigned       taken;
        int unsigned       walk_len;
        int unsigned       steps;
        logic [LINK_W-1:0] pg;
        logic [LINK_W-1:0] alloc_head;
        logic [LINK_W-1:0] tail;
        logic [LINK_W-1:0] nxt;
        res.status = STAT_IGNORED;
        res.frame  = NONE_LINK;
        case (item.op)
            OP_ALLOC:
            begin
                if (item.count == '0)
                    res.status = STAT_IGNORED;
                else if (item.count > free_count)
                    res.status = STAT_SHORT;
                else
                begin
                    alloc_head = NONE_LINK;
                    taken      = 0;
                    for (i = 0; i < item.count; i++)
                    begin
                        pg = head_frame;
                        if (pg >= NONE_LINK)
                            break;
                        head_frame                = link_mem[pg[IDX_W-1:0]];
                        link_mem[pg[IDX_W-1:0]]   = alloc_head;
                        alloc_head                = pg;
                        taken++;
                    end
                    free_count -= taken;
                    res.status = STAT_DONE;
                    res.frame  = alloc_head;
                end
            end
            OP_FREE:
            begin
                if (item.page < NONE_LINK)
                begin
                    tail     = item.page;
                    walk_len = 1;
                    steps    = 0;
                    while (steps < PAGES - 1)
                    begin
                        nxt = link_mem[tail[IDX_W-1:0]];
                        if (nxt >= NONE_LINK)
                            break;
                        tail = nxt;
                        walk_len++;
                        steps++;
                    end
                    link_mem[tail[IDX_W-1:0]] = head_frame;
                    head_frame     = item.page;
                    free_count     = free_count + walk_len;
                    if (free_count > PAGES)
                        free_count = PAGES;
                    res.status = STAT_DONE;
                    res.frame  = item.page;
                end
            end
            OP_LINK:
            begin
                if (item.page < NONE_LINK)
                begin
                    res.status = STAT_DONE;
                    res.frame  = link_mem[item.page[IDX_W-1:0]];
                end
            end
            default:
                res.status = STAT_IGNORED;
        endcase
        if (res.frame < NONE_LINK)
            res.frame_addr = ADDR_W'(res.frame) * ADDR_W'(PAGE_BYTES);
        else
            res.frame_addr = '0;
        res.free_pages = COUNT_W'(free_count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PAGES; k++)
                link_mem[k[IDX_W-1:0]] = (k == 0) ? NONE_LINK : LINK_W'(k - 1);
            head_frame = LINK_W'(PAGES - 1);
            free_count = PAGES;
            expected_rsp_q.delete();
            waiting_count = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                    report_mismatch("result with nothing outstanding",
                                    32'(rsp.frame), 32'd0);
                else
                begin
                    oldest_rsp = expected_rsp_q.pop_front();
                    if (rsp.status !== oldest_rsp.status)
                        report_mismatch("status", 32'(rsp.status),
                                        32'(oldest_rsp.status));
                    if (rsp.frame !== oldest_rsp.frame)
                        report_mismatch("frame", 32'(rsp.frame),
                                        32'(oldest_rsp.frame));
                    if (rsp.frame_addr !== oldest_rsp.frame_addr)
                        report_mismatch("frame_addr", 32'(rsp.frame_addr),
                                        32'(oldest_rsp.frame_addr));
                    if (rsp.free_pages !== oldest_rsp.free_pages)
                        report_mismatch("free_pages", 32'(rsp.free_pages),
                                        32'(oldest_rsp.free_pages));
                end
            end
            if (req_valid && !req_stall)
            begin
                predict_result(req, new_rsp);
                expected_rsp_q.push_back(new_rsp);
            end
            waiting_count = expected_rsp_q.size();
        end
    end

endmodule

### tb/page_frame_free_list_allocator_tb.sv
module page_frame_free_list_allocator_tb;
    import pffl_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int QUIET_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASE_ITEMS   = 270;
    localparam int PHASES        = 4;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    pffl_req_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    pffl_rsp_t rsp;
    int        errors;
    int        outstanding;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    logic        noisy = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    int unsigned hold_left = 0;

    pffl_req_t         sent_q[$];
    pffl_req_t         answered;
    logic [LINK_W-1:0] held_q[$];

    page_frame_free_list_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    page_frame_free_list_allocator_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // keep the heads of allocated lists so that they can be freed later
    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall && sent_q.size() != 0)
        begin
            answered = sent_q.pop_front();
            if (answered.op == OP_ALLOC && rsp.status == STAT_DONE && rsp.frame < NONE_LINK)
                held_q.push_back(rsp.frame);
        end
        if (req_valid && !req_stall)
            sent_q.push_back(req);
    end

    task automatic send_req(input logic [OP_W-1:0] op, input logic [COUNT_W-1:0] count,
                            input logic [LINK_W-1:0] page);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req.op     <= op;
        req.count  <= count;
        req.page   <= page;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        int unsigned        roll;
        int unsigned        size_roll;
        int unsigned        pick;
        logic [OP_W-1:0]    op;
        logic [COUNT_W-1:0] count;
        logic [LINK_W-1:0]  page;
        roll  = $urandom_range(0, 99);
        op    = OP_LINK;
        count = COUNT_W'($urandom);
        page  = LINK_W'($urandom_range(0, PAGES - 1));
        if (noisy && roll < 12)
        begin
            case ($urandom_range(0, 3))
                0: op = OP_UNUSED;
                1: op = OP_FREE;
                2:
                begin
                    op    = OP_ALLOC;
                    count = '0;
                end
                default:
                begin
                    op   = ($urandom_range(0, 1) != 0) ? OP_FREE : OP_LINK;
                    page = LINK_W'($urandom_range(PAGES, 255));
                end
            endcase
        end
        else if (roll < 40 || (held_q.size() == 0 && roll < 80))
        begin
            op        = OP_ALLOC;
            size_roll = $urandom_range(0, 99);
            if (size_roll < 70)
                count = COUNT_W'($urandom_range(1, 6));
            else if (size_roll < 92)
                count = COUNT_W'($urandom_range(7, 40));
            else if (size_roll < 97)
                count = COUNT_W'($urandom_range(41, PAGES - 1));
            else
                count = COUNT_W'($urandom_range(PAGES, 255));
        end
        else if (roll < 80)
        begin
            pick = $urandom_range(0, held_q.size() - 1);
            op   = OP_FREE;
            page = held_q[pick];
            held_q.delete(pick);
        end
        else if (roll >= 97)
            page = LINK_W'($urandom_range(PAGES, 255));
        send_req(op, count, page);
    endtask

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("page_frame_free_list_allocator_tb: errors");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int n;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(OP_LINK, 8'd0, 8'd0);
        send_req(OP_LINK, 8'hFF, 8'd127);
        send_req(OP_LINK, 8'd0, NONE_LINK);
        send_req(OP_LINK, 8'd0, 8'hFF);
        send_req(OP_UNUSED, 8'hFF, 8'hFF);
        send_req(OP_ALLOC, 8'd0, 8'hFF);
        send_req(OP_ALLOC, 8'd129, 8'd0);
        send_req(OP_ALLOC, 8'hFF, 8'd0);
        send_req(OP_FREE, 8'd0, NONE_LINK);
        send_req(OP_FREE, 8'hFF, 8'hFF);
        send_req(OP_ALLOC, ALL_PAGES, 8'd0);
        send_req(OP_ALLOC, 8'd1, 8'd0);
        send_req(OP_FREE, 8'd0, 8'd0);
        send_req(OP_LINK, 8'd0, 8'd127);
        // free a frame that is already free, then run an allocate into the loop
        send_req(OP_ALLOC, 8'd120, 8'd0);
        send_req(OP_FREE, 8'd0, 8'd124);
        send_req(OP_ALLOC, 8'd12, 8'd0);
        // restore a clean chain; the second free walks a closed loop
        send_req(OP_FREE, 8'd0, 8'd119);
        send_req(OP_FREE, 8'd0, 8'd125);
        send_req(OP_ALLOC, 8'd1, 8'd0);
        send_req(OP_FREE, 8'd0, 8'd125);
        wait_drained();
        held_q.delete();

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 63;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 63;
                end
                default:
                begin
                    send_idle_pct = 23;
                    stall_pct     = 23;
                    noisy         = 1'b1;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 0 && n == 20)
                    hold_req <= ~hold_req;
                send_random();
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("page_frame_free_list_allocator_tb: clean");
        else
            $display("page_frame_free_list_allocator_tb: errors");
        $finish;
    end

endmodule
